// File: rtl/hsl2rgb_pkg.sv
// Shared widths, constants and types of the HSL to RGB converter.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  localparam int FracBits = 16;
  localparam int ValW     = FracBits + 1;      // fraction 0..1.0 inclusive
  localparam int TurnW    = FracBits + 3;      // hue position 0..6*ONE-1
  localparam int ProdW    = 2 * ValW;          // product of two fractions
  localparam int XW       = 2 * FracBits + 2;  // channel value, 2F fraction bits
  localparam int ByteW    = 8;

  localparam logic [ValW-1:0]  One  = ValW'(1) << FracBits;
  localparam logic [ValW-1:0]  Half = ValW'(1) << (FracBits - 1);

  localparam logic [TurnW-1:0] TurnOne   = TurnW'(1) << FracBits;
  localparam logic [TurnW-1:0] TurnTwo   = TurnW'(2) << FracBits;
  localparam logic [TurnW-1:0] TurnThree = TurnW'(3) << FracBits;
  localparam logic [TurnW-1:0] TurnFour  = TurnW'(4) << FracBits;
  localparam logic [TurnW-1:0] TurnFull  = TurnW'(6) << FracBits;

  localparam logic [ByteW-1:0] ByteMax = '1;

  // Piece of the hue ramp that a channel sits on.
  typedef enum logic [1:0] {
    SegRise,
    SegHigh,
    SegFall,
    SegLow
  } seg_e;

  // Colour levels and hue positions handed from the mix unit to the channels.
  typedef struct packed {
    logic [ValW-1:0]  m1;
    logic [ValW-1:0]  m2;
    logic [TurnW-1:0] t_r;
    logic [TurnW-1:0] t_g;
    logic [TurnW-1:0] t_b;
  } mix_t;

endpackage

// File: rtl/hsl2rgb_if.sv
// Valid/ready channel interfaces for HSL input and RGB output transactions.
`timescale 1ns / 1ps

interface hsl2rgb_hsl_if import hsl2rgb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FracBits-1:0] hue;
  logic [ValW-1:0]     saturation;
  logic [ValW-1:0]     lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hsl2rgb_rgb_if import hsl2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] red;
  logic [ByteW-1:0] green;
  logic [ByteW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/hsl_to_rgb_converter.sv
// Throughput: one transaction per cycle while the output register is not stalled.
// Five register stages, the last is the output register.
// The whole pipe advances when the output register is empty or being taken.
// Reset (rst_ni, asynchronous, active low) clears only the stage valid bits.
// Data registers carry no reset; no state outlives a transaction.
`timescale 1ns / 1ps

module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl2rgb_hsl_if.sink   hsl_i,
  hsl2rgb_rgb_if.source rgb_o
);

  localparam int Stages = 5;

  logic              en;
  logic [Stages-1:0] vld_d, vld_q;
  mix_t              mix;
  logic [ByteW-1:0]  red, green, blue;

  // Advance every stage together; hold all of them while a finished
  // transaction waits at the output. Bubbles travel as cleared valid bits.
  assign en          = ~vld_q[Stages-1] | rgb_o.ready;
  assign hsl_i.ready = en;

  assign vld_d = {vld_q[Stages-2:0], hsl_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Stages 1-2: clamp, the m1/m2 levels and the three hue positions.
  hsl2rgb_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (en),
    .hue_i   (hsl_i.hue),
    .sat_i   (hsl_i.saturation),
    .light_i (hsl_i.lightness),
    .mix_o   (mix)
  );

  // Stages 3-5: one ramp per channel, red at hue+1/3, green at hue, blue at hue-1/3.
  hsl2rgb_chan u_chan_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .m1_i   (mix.m1),
    .m2_i   (mix.m2),
    .t_i    (mix.t_r),
    .byte_o (red)
  );

  hsl2rgb_chan u_chan_g (
    .clk_i  (clk_i),
    .en_i   (en),
    .m1_i   (mix.m1),
    .m2_i   (mix.m2),
    .t_i    (mix.t_g),
    .byte_o (green)
  );

  hsl2rgb_chan u_chan_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .m1_i   (mix.m1),
    .m2_i   (mix.m2),
    .t_i    (mix.t_b),
    .byte_o (blue)
  );

  assign rgb_o.valid = vld_q[Stages-1];
  assign rgb_o.red   = red;
  assign rgb_o.green = green;
  assign rgb_o.blue  = blue;

  // A stall must freeze every valid bit in the pipe.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe valid bits moved during a stall");

  // An accepted transaction must occupy the first stage next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_i.valid && hsl_i.ready |=> vld_q[0])
    else $error("accepted transaction missing from first stage");

  // Input back-pressure only while a result waits at the output.
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsl_i.ready |-> rgb_o.valid && !rgb_o.ready)
    else $error("input stalled without a waiting result");

endmodule

// File: rtl/hsl2rgb_mix.sv
// Mix unit: clamps inputs, forms m1/m2 and the three hue positions (two stages).
`timescale 1ns / 1ps

module hsl2rgb_mix import hsl2rgb_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [FracBits-1:0] hue_i,
  input  logic [ValW-1:0]     sat_i,
  input  logic [ValW-1:0]     light_i,
  output mix_t                mix_o
);

  localparam int SumW = ProdW + 1;

  logic [ValW-1:0]  s_c, l_c;
  logic [ValW-1:0]  s_q, l_q;
  logic [ProdW-1:0] p_d, p_q;
  logic [TurnW-1:0] t_d, t_q;

  logic [SumW-1:0]  sum_lo, sum_hi, m2_w;
  logic [ValW-1:0]  m2_c, m1_c;
  logic [ValW:0]    twol, m1_w;
  logic [TurnW-1:0] tr_sum, tr_c, tb_c;
  mix_t             mix_d, mix_q;

  // Stage 1: clamp to 1.0, one product l*s, hue position 6*h.
  assign s_c = (sat_i > One) ? One : sat_i;
  assign l_c = (light_i > One) ? One : light_i;
  assign p_d = ProdW'(l_c) * ProdW'(s_c);
  assign t_d = (TurnW'(hue_i) << 2) + (TurnW'(hue_i) << 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_c;
      l_q <= l_c;
      p_q <= p_d;
      t_q <= t_d;
    end
  end

  // Stage 2: m2, m1 and the shifted hue positions.
  assign sum_lo = SumW'(p_q) + (SumW'(l_q) << FracBits);
  assign sum_hi = (SumW'(l_q) << FracBits) + (SumW'(s_q) << FracBits) - SumW'(p_q);
  assign m2_w   = ((l_q < Half) ? sum_lo : sum_hi) >> FracBits;
  assign m2_c   = (m2_w > SumW'(One)) ? One : m2_w[ValW-1:0];

  assign twol = {l_q, 1'b0};
  assign m1_w = (twol >= {1'b0, m2_c}) ? (twol - {1'b0, m2_c}) : '0;
  assign m1_c = (m1_w > {1'b0, One}) ? One : m1_w[ValW-1:0];

  assign tr_sum = t_q + TurnTwo;
  assign tr_c   = (tr_sum >= TurnFull) ? (tr_sum - TurnFull) : tr_sum;
  assign tb_c   = (t_q >= TurnTwo) ? (t_q - TurnTwo) : (t_q + TurnFour);

  always_comb begin
    mix_d.m1  = m1_c;
    mix_d.m2  = m2_c;
    mix_d.t_r = tr_c;
    mix_d.t_g = t_q;
    mix_d.t_b = tb_c;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

// File: rtl/hsl2rgb_chan.sv
// One colour channel: hue ramp product, level sum and byte scaling (three stages).
`timescale 1ns / 1ps

module hsl2rgb_chan import hsl2rgb_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ValW-1:0]  m1_i,
  input  logic [ValW-1:0]  m2_i,
  input  logic [TurnW-1:0] t_i,
  output logic [ByteW-1:0] byte_o
);

  localparam int ScW = XW + ByteW;

  logic [ValW-1:0]  d_c, f_c;
  logic [TurnW-1:0] fall_c;
  seg_e             seg_c, seg_q;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [ValW-1:0]  m1_q, m2_q;
  logic [XW-1:0]    x_d, x_q;
  logic [ScW-1:0]   sc_c, sc_hi;
  logic [ByteW-1:0] byte_d, byte_q;

  // Stage 3: pick the ramp piece and its slope factor, multiply.
  assign d_c    = (m2_i >= m1_i) ? (m2_i - m1_i) : '0;
  assign fall_c = TurnFour - t_i;

  always_comb begin
    if (t_i < TurnOne) begin
      seg_c = SegRise;
      f_c   = t_i[ValW-1:0];
    end else if (t_i < TurnThree) begin
      seg_c = SegHigh;
      f_c   = '0;
    end else if (t_i < TurnFour) begin
      seg_c = SegFall;
      f_c   = fall_c[ValW-1:0];
    end else begin
      seg_c = SegLow;
      f_c   = '0;
    end
  end

  assign prod_d = ProdW'(d_c) * ProdW'(f_c);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      seg_q  <= seg_c;
      m1_q   <= m1_i;
      m2_q   <= m2_i;
    end
  end

  // Stage 4: channel level with 2F fraction bits.
  always_comb begin
    case (seg_q)
      SegHigh: x_d = XW'(m2_q) << FracBits;
      default: x_d = (XW'(m1_q) << FracBits) + XW'(prod_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
    end
  end

  // Stage 5: floor(x*255), capped.
  assign sc_c   = (ScW'(x_q) << ByteW) - ScW'(x_q);
  assign sc_hi  = sc_c >> (2 * FracBits);
  assign byte_d = (sc_hi > ScW'(ByteMax)) ? ByteMax : sc_hi[ByteW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule
